/* rtl/stcc_pkg.sv */
// ----------------------------------------------------------------------------
// stcc_pkg
// Shared sizes for the sorted-table code unit converter.
// ----------------------------------------------------------------------------
package stcc_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int UNIT_W      = 16;
  localparam int ENTRY_W     = 2 * UNIT_W;
  localparam int INDEX_W     = 13;
  localparam int CFG_W       = 14;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

endpackage

/* rtl/stcc_pair_ram.sv */
// ----------------------------------------------------------------------------
// stcc_pair_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stcc_pair_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/stcc_search.sv */
// ----------------------------------------------------------------------------
// stcc_search
// Item decode and binary search sequencer over the pair RAM.
// ----------------------------------------------------------------------------
module stcc_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [stcc_pkg::INDEX_W-1:0]  in_entry_index,
  input  logic [stcc_pkg::UNIT_W-1:0]   in_entry_key,
  input  logic [stcc_pkg::UNIT_W-1:0]   in_entry_value,
  input  logic [stcc_pkg::UNIT_W-1:0]   in_code_unit,
  input  logic [stcc_pkg::COUNT_W-1:0]  search_limit,
  output logic                          ram_we,
  output logic [stcc_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [stcc_pkg::ENTRY_W-1:0]  ram_wdata,
  output logic                          ram_re,
  output logic [stcc_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [stcc_pkg::ENTRY_W-1:0]  ram_rdata,
  output logic                          out_strobe,
  output logic [stcc_pkg::UNIT_W-1:0]   out_unit,
  output logic                          out_was_replaced
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  localparam int SUM_W = stcc_pkg::COUNT_W + 1;

  state_t                        state_r, state_nxt;
  logic [stcc_pkg::COUNT_W-1:0]  lo_r, lo_nxt;
  logic [stcc_pkg::COUNT_W-1:0]  hi_r, hi_nxt;
  logic [stcc_pkg::ADDR_W-1:0]   mid_r, mid_nxt;
  logic [stcc_pkg::UNIT_W-1:0]   unit_r, unit_nxt;
  logic                          strobe_r, strobe_nxt;
  logic [stcc_pkg::UNIT_W-1:0]   res_unit_r, res_unit_nxt;
  logic                          res_repl_r, res_repl_nxt;

  logic                          accept;
  logic [stcc_pkg::UNIT_W-1:0]   probe_key;
  logic [stcc_pkg::UNIT_W-1:0]   probe_value;
  logic [stcc_pkg::COUNT_W-1:0]  win_lo;
  logic [stcc_pkg::COUNT_W-1:0]  win_hi;
  logic [SUM_W-1:0]              win_sum;
  logic [stcc_pkg::ADDR_W-1:0]   win_mid;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign probe_key   = ram_rdata[stcc_pkg::ENTRY_W-1:stcc_pkg::UNIT_W];
  assign probe_value = ram_rdata[stcc_pkg::UNIT_W-1:0];

  // Load items write straight into the RAM while idle.
  assign ram_we    = accept && (in_operation == stcc_pkg::OP_LOAD) &&
                     (32'(in_entry_index) < 32'(stcc_pkg::TABLE_DEPTH));
  assign ram_waddr = stcc_pkg::ADDR_W'(in_entry_index);
  assign ram_wdata = {in_entry_key, in_entry_value};

  // Narrow the window from the last probe, or open it for a new item.
  always_comb begin
    win_lo = lo_r;
    win_hi = hi_r;
    if (state_r == ST_IDLE) begin
      win_lo = '0;
      win_hi = search_limit;
    end else if (unit_r < probe_key) begin
      win_hi = stcc_pkg::COUNT_W'(mid_r);
    end else begin
      win_lo = stcc_pkg::COUNT_W'(mid_r) + stcc_pkg::COUNT_W'(1);
    end
    win_sum = SUM_W'(win_lo) + SUM_W'(win_hi);
    win_mid = stcc_pkg::ADDR_W'(win_sum >> 1);
  end

  assign ram_raddr = win_mid;

  always_comb begin
    state_nxt    = state_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    unit_nxt     = unit_r;
    strobe_nxt   = 1'b0;
    res_unit_nxt = res_unit_r;
    res_repl_nxt = res_repl_r;
    ram_re       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == stcc_pkg::OP_CONVERT)) begin
          unit_nxt = in_code_unit;
          lo_nxt   = win_lo;
          hi_nxt   = win_hi;
          mid_nxt  = win_mid;
          if (win_lo < win_hi) begin
            ram_re    = 1'b1;
            state_nxt = ST_SEARCH;
          end else begin
            // empty table: pass the unit through at once
            strobe_nxt   = 1'b1;
            res_unit_nxt = in_code_unit;
            res_repl_nxt = 1'b0;
          end
        end
      end
      ST_SEARCH: begin
        if (unit_r == probe_key) begin
          strobe_nxt   = 1'b1;
          state_nxt    = ST_IDLE;
          res_repl_nxt = (probe_value != '0);
          res_unit_nxt = (probe_value != '0) ? probe_value : unit_r;
        end else if (win_lo < win_hi) begin
          ram_re  = 1'b1;
          lo_nxt  = win_lo;
          hi_nxt  = win_hi;
          mid_nxt = win_mid;
        end else begin
          strobe_nxt   = 1'b1;
          state_nxt    = ST_IDLE;
          res_repl_nxt = 1'b0;
          res_unit_nxt = unit_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    unit_r     <= unit_nxt;
    res_unit_r <= res_unit_nxt;
    res_repl_r <= res_repl_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_unit         = res_unit_r;
  assign out_was_replaced = res_repl_r;

endmodule

/* rtl/sorted_table_char_converter.sv */
// ----------------------------------------------------------------------------
// sorted_table_char_converter
// Load items write the table and give no result. A convert item runs a
// binary search with one RAM probe per search step, then registers its
// result in the output register; when entry_count is zero it skips the
// search and passes the code unit through. busy is high while the search
// runs; the next item is accepted in the cycle its result is out.
// The receiver cannot stall.
// Synchronous reset clears control and entry_count; table RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_table_char_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [stcc_pkg::INDEX_W-1:0]  in_entry_index,
  input  logic [stcc_pkg::UNIT_W-1:0]   in_entry_key,
  input  logic [stcc_pkg::UNIT_W-1:0]   in_entry_value,
  input  logic [stcc_pkg::UNIT_W-1:0]   in_code_unit,
  input  logic                          cfg_we,
  input  logic [stcc_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                          out_strobe,
  output logic [stcc_pkg::UNIT_W-1:0]   out_unit,
  output logic                          out_was_replaced
);

  logic [stcc_pkg::CFG_W-1:0]    entry_count_r;
  logic [stcc_pkg::COUNT_W-1:0]  search_limit;
  logic                          ram_we;
  logic [stcc_pkg::ADDR_W-1:0]   ram_waddr;
  logic [stcc_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [stcc_pkg::ADDR_W-1:0]   ram_raddr;
  logic [stcc_pkg::ENTRY_W-1:0]  ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // Clamp the count to the table depth.
  assign search_limit = (32'(entry_count_r) > 32'(stcc_pkg::TABLE_DEPTH)) ?
                        stcc_pkg::COUNT_W'(stcc_pkg::TABLE_DEPTH) :
                        stcc_pkg::COUNT_W'(entry_count_r);

  stcc_search u_search (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_entry_key     (in_entry_key),
    .in_entry_value   (in_entry_value),
    .in_code_unit     (in_code_unit),
    .search_limit     (search_limit),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_strobe       (out_strobe),
    .out_unit         (out_unit),
    .out_was_replaced (out_was_replaced)
  );

  stcc_pair_ram #(
    .DEPTH (stcc_pkg::TABLE_DEPTH),
    .WIDTH (stcc_pkg::ENTRY_W)
  ) u_pair_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
